>>> hdl/cpfa_pkg.sv
// Shared constants, types and controller/datapath interface structs for the frame allocator.
package cpfa_pkg;

    localparam int FRAME_COUNT     = 64;
    localparam int MAX_SLOTS       = 16;
    localparam int PROCESS_ID_BITS = 8;

    localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NSLOT_W = $clog2(MAX_SLOTS + 1);
    localparam int CNT_W   = $clog2(FRAME_COUNT + 1);
    localparam int ENTRY_W = PROCESS_ID_BITS + SLOT_W;

    // fixed port widths
    localparam int PAGES_W = 5;
    localparam int OCNT_W  = 7;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UNLOAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_CLOCK,
        ST_INSTALL,
        ST_UNLOAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic scan_start;
        logic scan_run;
        logic free_en;
        logic stage_hit;
        logic stage_unload;
        logic clock_step;
        logic install;
        logic emit;
        logic next_slot;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic ref_clear;
        logic out_free;
        logic last_slot;
        logic is_unload;
        logic in_unload;
        logic in_empty;
    } ctrl_stat_t;

endpackage

>>> hdl/cpfa_ctrl.sv
// Sequencing state machine: lookup scan, clock sweep, install, unload scan, result hand-off.
module cpfa_ctrl
    import cpfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    if (stat.in_unload)
                    begin
                        ctl.scan_start = 1'b1;
                        state_next     = ST_UNLOAD;
                    end
                    else if (!stat.in_empty)
                    begin
                        ctl.scan_start = 1'b1;
                        state_next     = ST_FIND;
                    end
                end
            end
            ST_FIND:
            begin
                ctl.scan_run = 1'b1;
                if (stat.hit)
                begin
                    ctl.stage_hit = 1'b1;
                    state_next    = ST_EMIT;
                end
                else if (stat.scan_done)
                begin
                    state_next = ST_CLOCK;
                end
            end
            ST_CLOCK:
            begin
                ctl.clock_step = 1'b1;
                if (stat.ref_clear)
                begin
                    state_next = ST_INSTALL;
                end
            end
            ST_INSTALL:
            begin
                ctl.install = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_UNLOAD:
            begin
                ctl.scan_run = 1'b1;
                ctl.free_en  = 1'b1;
                if (stat.scan_done)
                begin
                    ctl.stage_unload = 1'b1;
                    state_next       = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit = 1'b1;
                    if (stat.is_unload || stat.last_slot)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ctl.next_slot  = 1'b1;
                        ctl.scan_start = 1'b1;
                        state_next     = ST_FIND;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/cpfa_dp.sv
// Frame table datapath: valid/reference bits, owner memory, clock hand, counters, result register.
module cpfa_dp
    import cpfa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd,
    input  logic [PROCESS_ID_BITS-1:0] process_id,
    input  logic [PAGES_W-1:0]         pages_needed,
    input  ctrl_cmd_t                  ctl,
    output ctrl_stat_t                 stat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [FRAME_W-1:0]         frame_index,
    output logic [SLOT_W-1:0]          page_slot,
    output logic                       newly_loaded,
    output logic                       evicted,
    output logic [PROCESS_ID_BITS-1:0] evicted_process,
    output logic [SLOT_W-1:0]          evicted_slot,
    output logic [OCNT_W-1:0]          freed_count,
    output logic [OCNT_W-1:0]          occupied_count,
    output logic                       last
);

    localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAME_COUNT - 1);

    // owner store: {process, slot}, only meaningful where the valid bit is set
    logic [ENTRY_W-1:0] owner_mem [FRAME_COUNT];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [FRAME_W-1:0] rd_addr;

    logic [FRAME_COUNT-1:0] valid_reg, valid_next;
    logic [FRAME_COUNT-1:0] ref_reg, ref_next;
    logic [FRAME_W-1:0]     hand_reg, hand_next;
    logic [CNT_W-1:0]       occ_reg, occ_next;
    logic [CNT_W-1:0]       freed_reg, freed_next;

    logic [FRAME_W-1:0] scan_addr_reg;
    logic [FRAME_W-1:0] cmp_idx_reg;
    logic               cmp_en_reg;
    logic               out_valid_reg;

    // item context
    logic                       unload_reg;
    logic [PROCESS_ID_BITS-1:0] pid_reg;
    logic [NSLOT_W-1:0]         n_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic [FRAME_W-1:0]         chosen_reg;

    // staged result
    logic [FRAME_W-1:0]         res_frame_reg;
    logic [SLOT_W-1:0]          res_slot_reg;
    logic                       res_nl_reg;
    logic                       res_ev_reg;
    logic [PROCESS_ID_BITS-1:0] res_evp_reg;
    logic [SLOT_W-1:0]          res_evs_reg;
    logic [CNT_W-1:0]           res_freed_reg;
    logic [CNT_W-1:0]           res_occ_reg;

    // output register
    logic [FRAME_W-1:0]         o_frame_reg;
    logic [SLOT_W-1:0]          o_slot_reg;
    logic                       o_nl_reg;
    logic                       o_ev_reg;
    logic [PROCESS_ID_BITS-1:0] o_evp_reg;
    logic [SLOT_W-1:0]          o_evs_reg;
    logic [CNT_W-1:0]           o_freed_reg;
    logic [CNT_W-1:0]           o_occ_reg;
    logic                       o_last_reg;

    logic [PROCESS_ID_BITS-1:0] own_pid;
    logic [SLOT_W-1:0]          own_slot;
    logic                       cmp_vbit;
    logic                       pid_match;
    logic                       hit;
    logic                       free_match;
    logic                       last_slot;
    logic                       chosen_valid;
    logic [NSLOT_W-1:0]         n_clamped;

    assign own_pid  = rd_data_reg[ENTRY_W-1:SLOT_W];
    assign own_slot = rd_data_reg[SLOT_W-1:0];
    assign cmp_vbit = valid_reg[cmp_idx_reg];

    assign pid_match  = cmp_en_reg && cmp_vbit && (own_pid == pid_reg);
    assign hit        = pid_match && (own_slot == slot_reg);
    assign free_match = pid_match && (NSLOT_W'(own_slot) < n_reg);
    assign last_slot  = (NSLOT_W'(slot_reg) + NSLOT_W'(1)) == n_reg;
    assign chosen_valid = valid_reg[chosen_reg];

    assign n_clamped = (pages_needed > PAGES_W'(MAX_SLOTS)) ? NSLOT_W'(MAX_SLOTS)
                                                            : NSLOT_W'(pages_needed);

    assign rd_addr = ctl.clock_step ? hand_reg : scan_addr_reg;

    always_comb
    begin
        stat.hit       = hit;
        stat.scan_done = cmp_en_reg && (cmp_idx_reg == LAST_FRAME);
        stat.ref_clear = !ref_reg[hand_reg];
        stat.out_free  = !out_valid_reg || out_ready;
        stat.last_slot = last_slot;
        stat.is_unload = unload_reg;
        stat.in_unload = (cmd == CMD_UNLOAD);
        stat.in_empty  = (pages_needed == '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.install)
        begin
            owner_mem[chosen_reg] <= {pid_reg, slot_reg};
        end
        rd_data_reg <= owner_mem[rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        ref_next   = ref_reg;
        hand_next  = hand_reg;
        occ_next   = occ_reg;
        freed_next = freed_reg;
        if (ctl.load_item)
        begin
            freed_next = '0;
        end
        if (ctl.free_en && free_match)
        begin
            valid_next[cmp_idx_reg] = 1'b0;
            freed_next              = freed_reg + CNT_W'(1);
            if (occ_reg != '0)
            begin
                occ_next = occ_reg - CNT_W'(1);
            end
        end
        if (ctl.clock_step)
        begin
            ref_next[hand_reg] = 1'b0;
            hand_next = (hand_reg == LAST_FRAME) ? '0 : hand_reg + FRAME_W'(1);
        end
        if (ctl.install)
        begin
            valid_next[chosen_reg] = 1'b1;
            ref_next[chosen_reg]   = 1'b1;
            if (!chosen_valid)
            begin
                occ_next = occ_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            ref_reg       <= '0;
            hand_reg      <= '0;
            occ_reg       <= '0;
            freed_reg     <= '0;
            scan_addr_reg <= '0;
            cmp_idx_reg   <= '0;
            cmp_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            ref_reg   <= ref_next;
            hand_reg  <= hand_next;
            occ_reg   <= occ_next;
            freed_reg <= freed_next;
            if (ctl.scan_start)
            begin
                scan_addr_reg <= '0;
                cmp_en_reg    <= 1'b0;
            end
            else if (ctl.scan_run)
            begin
                scan_addr_reg <= (scan_addr_reg == LAST_FRAME) ? '0
                                                               : scan_addr_reg + FRAME_W'(1);
                cmp_idx_reg   <= scan_addr_reg;
                cmp_en_reg    <= 1'b1;
            end
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            unload_reg <= (cmd == CMD_UNLOAD);
            pid_reg    <= process_id;
            n_reg      <= n_clamped;
            slot_reg   <= '0;
        end
        else if (ctl.next_slot)
        begin
            slot_reg <= slot_reg + SLOT_W'(1);
        end

        if (ctl.clock_step && !ref_reg[hand_reg])
        begin
            chosen_reg <= hand_reg;
        end

        if (ctl.stage_hit)
        begin
            res_frame_reg <= cmp_idx_reg;
            res_slot_reg  <= slot_reg;
            res_nl_reg    <= 1'b0;
            res_ev_reg    <= 1'b0;
            res_evp_reg   <= '0;
            res_evs_reg   <= '0;
            res_freed_reg <= '0;
            res_occ_reg   <= occ_reg;
        end
        else if (ctl.install)
        begin
            res_frame_reg <= chosen_reg;
            res_slot_reg  <= slot_reg;
            res_nl_reg    <= 1'b1;
            res_ev_reg    <= chosen_valid;
            res_evp_reg   <= chosen_valid ? own_pid : '0;
            res_evs_reg   <= chosen_valid ? own_slot : '0;
            res_freed_reg <= '0;
            res_occ_reg   <= occ_next;
        end
        else if (ctl.stage_unload)
        begin
            res_frame_reg <= '0;
            res_slot_reg  <= '0;
            res_nl_reg    <= 1'b0;
            res_ev_reg    <= 1'b0;
            res_evp_reg   <= '0;
            res_evs_reg   <= '0;
            res_freed_reg <= freed_next;
            res_occ_reg   <= occ_next;
        end

        if (ctl.emit)
        begin
            o_frame_reg <= res_frame_reg;
            o_slot_reg  <= res_slot_reg;
            o_nl_reg    <= res_nl_reg;
            o_ev_reg    <= res_ev_reg;
            o_evp_reg   <= res_evp_reg;
            o_evs_reg   <= res_evs_reg;
            o_freed_reg <= res_freed_reg;
            o_occ_reg   <= res_occ_reg;
            o_last_reg  <= unload_reg || last_slot;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_index     = o_frame_reg;
    assign page_slot       = o_slot_reg;
    assign newly_loaded    = o_nl_reg;
    assign evicted         = o_ev_reg;
    assign evicted_process = o_evp_reg;
    assign evicted_slot    = o_evs_reg;
    assign freed_count     = OCNT_W'(o_freed_reg);
    assign occupied_count  = OCNT_W'(o_occ_reg);
    assign last            = o_last_reg;

endmodule

>>> hdl/clock_page_frame_allocator.sv
// Top level of the second-chance clock page-frame allocator.
//
// A load beat walks page slots 0..pages_needed-1 (clamped to MAX_SLOTS) of one
// process and returns one result beat per slot; an unload beat frees every
// frame of the process in those slots and returns a single beat with the freed
// count. One item is worked at a time. Every table access goes through the
// single read port of the owner memory, one frame per cycle:
//   - slot already held:  lookup scan up to the hit, then hand-off
//   - slot missing:       full lookup scan, then clock sweep
//                         (one reference bit per cycle), install, hand-off
//   - unload:             full scan, then hand-off
// Each input beat is taken in idle. A zero slot count load returns nothing.
// Results sit in an output register, so in_ready comes back once the last
// beat is registered even if the sink has not taken it.
// No clearing pass after reset: valid and reference bits are flops cleared by
// reset, and owner entries are only read behind a set valid bit.
module clock_page_frame_allocator
    import cpfa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic [PROCESS_ID_BITS-1:0] process_id,
    input  logic [PAGES_W-1:0]         pages_needed,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [FRAME_W-1:0]         frame_index,
    output logic [SLOT_W-1:0]          page_slot,
    output logic                       newly_loaded,
    output logic                       evicted,
    output logic [PROCESS_ID_BITS-1:0] evicted_process,
    output logic [SLOT_W-1:0]          evicted_slot,
    output logic [OCNT_W-1:0]          freed_count,
    output logic [OCNT_W-1:0]          occupied_count,
    output logic                       last
);

    ctrl_cmd_t  ctl;
    ctrl_stat_t stat;

    // sequencer: owns the handshake on the input side
    cpfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // frame table, clock hand, counters and the output beat register
    cpfa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .process_id      (process_id),
        .pages_needed    (pages_needed),
        .ctl             (ctl),
        .stat            (stat),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_index     (frame_index),
        .page_slot       (page_slot),
        .newly_loaded    (newly_loaded),
        .evicted         (evicted),
        .evicted_process (evicted_process),
        .evicted_slot    (evicted_slot),
        .freed_count     (freed_count),
        .occupied_count  (occupied_count),
        .last            (last)
    );

endmodule

>>> hdl/cpfa_checker.sv
// Port-level checks for the frame allocator, bound to the top level.
module cpfa_checker
    import cpfa_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       cmd,
    input logic [PROCESS_ID_BITS-1:0] process_id,
    input logic [PAGES_W-1:0]         pages_needed,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [FRAME_W-1:0]         frame_index,
    input logic [SLOT_W-1:0]          page_slot,
    input logic                       newly_loaded,
    input logic                       evicted,
    input logic [PROCESS_ID_BITS-1:0] evicted_process,
    input logic [SLOT_W-1:0]          evicted_slot,
    input logic [OCNT_W-1:0]          freed_count,
    input logic [OCNT_W-1:0]          occupied_count,
    input logic                       last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_index)
            && $stable(page_slot) && $stable(last) && $stable(occupied_count))
        else $error("result beat changed while stalled");

    // only a new install can report an eviction
    a_evict_new: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> newly_loaded && freed_count == '0)
        else $error("eviction without a new load");

    // an unload beat is a single, final beat with no load fields
    a_unload_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && freed_count != '0 |-> last && !newly_loaded && !evicted
            && frame_index == '0 && page_slot == '0)
        else $error("malformed unload beat");

    // occupancy is bounded, and a fresh install leaves at least one frame in use
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupied_count <= OCNT_W'(FRAME_COUNT)
            && (!newly_loaded || occupied_count != '0))
        else $error("occupied count out of range");

endmodule

bind clock_page_frame_allocator cpfa_checker u_cpfa_checker (.*);
